[rtl/bls_pkg.sv]
// ----------------------------------------------------------------------------
// bls_pkg
// Types and constants for the Bresenham line stepper: item layouts for the
// request and response channels, function codes and internal widths.
// ----------------------------------------------------------------------------
package bls_pkg;

   // coordinate width of every point field
   localparam int COORD_BITS = 12;
   // color width
   localparam int COLOR_BITS = 24;
   // decision term width, holds -2*major .. 2*minor
   localparam int DEC_BITS   = COORD_BITS + 3;

   // result queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   // function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   // fold flag bit positions
   localparam int FOLD_INV_X = 0;
   localparam int FOLD_INV_Y = 1;
   localparam int FOLD_SWAP  = 2;

   // request item
   typedef struct packed {
      logic                          func;
      logic signed [COORD_BITS-1:0]  x_start;
      logic signed [COORD_BITS-1:0]  y_start;
      logic signed [COORD_BITS-1:0]  x_end;
      logic signed [COORD_BITS-1:0]  y_end;
      logic        [COLOR_BITS-1:0]  color;
   } req_type;

   // response item
   typedef struct packed {
      logic signed [COORD_BITS-1:0]  point_x;
      logic signed [COORD_BITS-1:0]  point_y;
      logic        [COLOR_BITS-1:0]  point_color;
      logic                          last_point;
   } rsp_type;

endpackage

[rtl/bresenham_line_stepper_unit.sv]
// ----------------------------------------------------------------------------
// bresenham_line_stepper_unit
// Integer Bresenham line rasterizer for all octants, one pixel per step item.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (valid/ready) carries one item: a start item (func = start)
//    loads a new line and returns two points, the start point and then the
//    end point; a step item returns the next pixel of the line, with
//    last_point set on the final one (the end point again). A step item while
//    no line is active is consumed and returns nothing. A start item while a
//    line is active abandons it.
//  - rsp channel (valid/ready) returns points in order.
//  - the points of an item are written into the result queue when the item is
//    accepted. All line math for an item is done in the cycle it is accepted.
//  - throughput: one item per cycle for step items while rsp_ready is high;
//    a start item returns two points. The rate is set by the 4-entry result
//    queue: req_ready is high while at most 2 entries are held, so a stalled
//    receiver back-pressures the requester after a few items; nothing is lost.
//  - reset (synchronous, active high) empties the queue and leaves the block
//    idle with no line in progress.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bls_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bls_pkg::rsp_type rsp_data
);

   localparam int N  = bls_pkg::COORD_BITS;
   localparam int DW = bls_pkg::DEC_BITS;
   localparam int QD = bls_pkg::QUEUE_DEPTH;
   localparam int PB = bls_pkg::PTR_BITS;
   localparam int CB = bls_pkg::CNT_BITS;

   // line state
   logic                          active_ff,    active_in;
   logic [N-1:0]                  major_pos_ff, major_pos_in;
   logic [N-1:0]                  minor_pos_ff, minor_pos_in;
   logic [N-1:0]                  major_len_ff, major_len_in;
   logic [N-1:0]                  minor_len_ff, minor_len_in;
   logic [DW-1:0]                 decision_ff,  decision_in;
   logic [2:0]                    fold_ff,      fold_in;
   logic [N-1:0]                  orig_x_ff,    orig_x_in;
   logic [N-1:0]                  orig_y_ff,    orig_y_in;
   logic [bls_pkg::COLOR_BITS-1:0] color_ff,    color_in;

   // result queue
   bls_pkg::rsp_type              queue_ff [QD];
   logic [PB-1:0]                 wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]                 rd_ptr_ff, rd_ptr_in;
   logic [CB-1:0]                 count_ff,  count_in;
   logic [PB-1:0]                 wr_ptr_nx;

   logic                          req_fire, rsp_fire, is_start;
   logic [1:0]                    push_n;
   bls_pkg::rsp_type              res0, res1;

   // start folding
   logic [N:0]                    dx_full, dy_full;
   logic [N:0]                    adx_full, ady_full;
   logic [N-1:0]                  adx, ady, maj0, min0;
   logic                          swap0;
   logic [DW-1:0]                 dec0;

   // step math
   logic                          dec_pos, step_last;
   logic [DW-1:0]                 ext_min, ext_maj, diff2, dec_step;
   logic [N-1:0]                  maj_nx, min_nx, px_f, py_f, px, py;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign is_start = (req_data.func == bls_pkg::FUNC_START);

   // fold a new line into the first octant
   always_comb begin
      dx_full  = {req_data.x_end[N-1], req_data.x_end} -
                 {req_data.x_start[N-1], req_data.x_start};
      dy_full  = {req_data.y_end[N-1], req_data.y_end} -
                 {req_data.y_start[N-1], req_data.y_start};
      adx_full = dx_full[N] ? (~dx_full + 1'b1) : dx_full;
      ady_full = dy_full[N] ? (~dy_full + 1'b1) : dy_full;
      adx      = adx_full[N-1:0];
      ady      = ady_full[N-1:0];
      swap0    = (adx < ady);
      maj0     = swap0 ? ady : adx;
      min0     = swap0 ? adx : ady;
      dec0     = {2'b00, min0, 1'b0} - {3'b000, maj0};
   end

   // advance one pixel and map it back to the real octant
   always_comb begin
      dec_pos   = !decision_ff[DW-1] && (decision_ff != '0);
      ext_min   = {3'b000, minor_len_ff};
      ext_maj   = {3'b000, major_len_ff};
      diff2     = {ext_min[DW-2:0], 1'b0} - {ext_maj[DW-2:0], 1'b0};
      dec_step  = dec_pos ? (decision_ff + diff2)
                          : (decision_ff + {ext_min[DW-2:0], 1'b0});
      maj_nx    = major_pos_ff + 1'b1;
      min_nx    = dec_pos ? (minor_pos_ff + 1'b1) : minor_pos_ff;
      step_last = (maj_nx >= major_len_ff);
      px_f      = fold_ff[bls_pkg::FOLD_SWAP] ? min_nx : maj_nx;
      py_f      = fold_ff[bls_pkg::FOLD_SWAP] ? maj_nx : min_nx;
      px        = (fold_ff[bls_pkg::FOLD_INV_X] ? (~px_f + 1'b1) : px_f) + orig_x_ff;
      py        = (fold_ff[bls_pkg::FOLD_INV_Y] ? (~py_f + 1'b1) : py_f) + orig_y_ff;
   end

   // next line state and the points to queue
   always_comb begin
      active_in    = active_ff;
      major_pos_in = major_pos_ff;
      minor_pos_in = minor_pos_ff;
      major_len_in = major_len_ff;
      minor_len_in = minor_len_ff;
      decision_in  = decision_ff;
      fold_in      = fold_ff;
      orig_x_in    = orig_x_ff;
      orig_y_in    = orig_y_ff;
      color_in     = color_ff;
      push_n       = 2'd0;

      res0.point_x     = px;
      res0.point_y     = py;
      res0.point_color = color_ff;
      res0.last_point  = step_last;
      res1             = res0;

      if (is_start) begin
         res0.point_x     = req_data.x_start;
         res0.point_y     = req_data.y_start;
         res0.point_color = req_data.color;
         res0.last_point  = 1'b0;
         res1.point_x     = req_data.x_end;
         res1.point_y     = req_data.y_end;
         res1.point_color = req_data.color;
         res1.last_point  = (maj0 == '0);
      end

      if (req_fire) begin
         if (is_start) begin
            push_n       = 2'd2;
            active_in    = (maj0 != '0);
            major_pos_in = '0;
            minor_pos_in = '0;
            major_len_in = maj0;
            minor_len_in = min0;
            decision_in  = dec0;
            fold_in      = {swap0, dy_full[N], dx_full[N]};
            orig_x_in    = req_data.x_start;
            orig_y_in    = req_data.y_start;
            color_in     = req_data.color;
         end else if (active_ff) begin
            push_n       = 2'd1;
            major_pos_in = maj_nx;
            minor_pos_in = min_nx;
            decision_in  = dec_step;
            if (step_last) begin
               active_in = 1'b0;
            end
         end
      end
   end

   // queue pointers and occupancy
   always_comb begin
      wr_ptr_nx = wr_ptr_ff + 1'b1;
      wr_ptr_in = wr_ptr_ff + push_n[PB-1:0];
      rd_ptr_in = rsp_fire ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + CB'(push_n) - CB'(rsp_fire);
   end

   assign req_ready = (count_ff <= CB'(QD - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = queue_ff[rd_ptr_ff];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // line registers, cleared on reset to match the idle state
   always_ff @(posedge clock) begin
      if (reset) begin
         major_pos_ff <= '0;
         minor_pos_ff <= '0;
         major_len_ff <= '0;
         minor_len_ff <= '0;
         decision_ff  <= '0;
         fold_ff      <= '0;
         orig_x_ff    <= '0;
         orig_y_ff    <= '0;
         color_ff     <= '0;
      end else begin
         major_pos_ff <= major_pos_in;
         minor_pos_ff <= minor_pos_in;
         major_len_ff <= major_len_in;
         minor_len_ff <= minor_len_in;
         decision_ff  <= decision_in;
         fold_ff      <= fold_in;
         orig_x_ff    <= orig_x_in;
         orig_y_ff    <= orig_y_in;
         color_ff     <= color_in;
      end
   end

   // queue payload, no reset needed
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_nx] <= res1;
      end
   end

   // queue never overflows
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(QD))
      else $error("result queue overflow");

   // an accepted item always finds room for two points
   a_room_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (count_ff <= CB'(QD - 2)))
      else $error("item accepted without queue room");

   // a zero-length line leaves the block idle
   a_zero_len_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_start && (maj0 == '0)) |=> !active_ff)
      else $error("zero-length line left active");

   // the final pixel of a line ends it
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !is_start && active_ff && step_last) |=> !active_ff)
      else $error("line still active after last pixel");

   // a step while idle queues nothing
   a_idle_step_silent: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !is_start && !active_ff) |-> (push_n == 2'd0))
      else $error("idle step produced a point");

endmodule
